@@ rtl/bir_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bir_pkg
// Shared types and constants of the bilinear resize block.
// ----------------------------------------------------------------------------
package bir_pkg;

  localparam int MAX_SRC_WIDTH  = 128;
  localparam int MAX_SRC_HEIGHT = 128;
  localparam int MAX_DST_WIDTH  = 256;
  localparam int MAX_DST_HEIGHT = 256;

  localparam int QUEUE_DEPTH = 2;
  localparam int DIV_W       = 32;   // dividend and quotient width

  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_COMP = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam logic [1:0] REG_SRC_W = 2'd0;
  localparam logic [1:0] REG_SRC_H = 2'd1;
  localparam logic [1:0] REG_DST_W = 2'd2;
  localparam logic [1:0] REG_DST_H = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] source_row;
    logic [6:0] source_col;
    logic [7:0] pixel_value;
    logic [7:0] target_row;
    logic [7:0] target_col;
  } cmd_t;

  // effective frame sizes after clamping
  typedef struct packed {
    logic [7:0] sw;
    logic [7:0] sh;
    logic [8:0] tw;
    logic [8:0] th;
  } geom_t;

endpackage
`default_nettype wire

@@ rtl/bir_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bir_front
// Holds the size registers, accepts items and classifies them for the queue.
// ----------------------------------------------------------------------------
module bir_front import bir_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [8:0]  cfg_data,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [39:0] in_tdata,
  input  wire logic        in_tuser,
  input  wire logic        q_full,
  output      logic        q_push,
  output      cmd_t        q_cmd,
  output      geom_t       geom
);

  logic [7:0] src_w_r, src_h_r;
  logic [8:0] dst_w_r, dst_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= 8'd128;
      src_h_r <= 8'd128;
      dst_w_r <= 9'd128;
      dst_h_r <= 9'd128;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SRC_W: src_w_r <= cfg_data[7:0];
        REG_SRC_H: src_h_r <= cfg_data[7:0];
        REG_DST_W: dst_w_r <= cfg_data;
        REG_DST_H: dst_h_r <= cfg_data;
        default:   ;
      endcase
    end
  end

  always_comb begin
    if (src_w_r == 8'd0)                      geom.sw = 8'd1;
    else if (32'(src_w_r) > MAX_SRC_WIDTH)    geom.sw = 8'(MAX_SRC_WIDTH);
    else                                      geom.sw = src_w_r;
    if (src_h_r == 8'd0)                      geom.sh = 8'd1;
    else if (32'(src_h_r) > MAX_SRC_HEIGHT)   geom.sh = 8'(MAX_SRC_HEIGHT);
    else                                      geom.sh = src_h_r;
    geom.tw = (32'(dst_w_r) > MAX_DST_WIDTH)  ? 9'(MAX_DST_WIDTH)  : dst_w_r;
    geom.th = (32'(dst_h_r) > MAX_DST_HEIGHT) ? 9'(MAX_DST_HEIGHT) : dst_h_r;
  end

  logic load_in_range;

  always_comb begin
    q_cmd.source_row  = in_tdata[6:0];
    q_cmd.source_col  = in_tdata[13:7];
    q_cmd.pixel_value = in_tdata[21:14];
    q_cmd.target_row  = in_tdata[29:22];
    q_cmd.target_col  = in_tdata[37:30];
    load_in_range = (32'(in_tdata[6:0]) < MAX_SRC_HEIGHT) &&
                    (32'(in_tdata[13:7]) < MAX_SRC_WIDTH);
    if (!in_tuser)
      q_cmd.kind = KIND_LOAD;
    else if ({1'b0, in_tdata[29:22]} >= geom.th || {1'b0, in_tdata[37:30]} >= geom.tw)
      q_cmd.kind = KIND_ERR;
    else
      q_cmd.kind = KIND_COMP;
  end

  assign in_tready = !q_full;
  // drop loads that fall outside the store
  assign q_push = in_tvalid && !q_full && (in_tuser || load_in_range);

endmodule
`default_nettype wire

@@ rtl/bir_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bir_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module bir_queue import bir_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  cmd_t      push_cmd,
  input  wire logic pop,
  output      logic full,
  output      logic empty,
  output      cmd_t head
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push)
        wr_ptr_r <= (32'(wr_ptr_r) == QUEUE_DEPTH - 1) ? '0 : PTR_W'(wr_ptr_r + 1'b1);
      if (pop)
        rd_ptr_r <= (32'(rd_ptr_r) == QUEUE_DEPTH - 1) ? '0 : PTR_W'(rd_ptr_r + 1'b1);
      if (push && !pop)      count_r <= CNT_W'(count_r + 1'b1);
      else if (pop && !push) count_r <= CNT_W'(count_r - 1'b1);
    end
  end

endmodule
`default_nettype wire

@@ rtl/bir_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bir_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bir_div import bir_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] dividend,
  input  wire logic [8:0]       divisor,
  output      logic             done,
  output      logic [DIV_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIV_W);

  logic [DIV_W-1:0] num_r;
  logic [8:0]       rem_r, div_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [9:0]       trial;
  logic             fits;

  assign trial    = {rem_r, num_r[DIV_W-1]};
  assign fits     = trial >= {1'b0, div_r};
  assign done     = done_r;
  assign quotient = num_r;

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      div_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? 9'(trial - {1'b0, div_r}) : trial[8:0];
      num_r <= {num_r[DIV_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= CNT_W'(cnt_r + 1'b1);
        if (32'(cnt_r) == DIV_W - 1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/bir_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bir_back
// Frame store, coordinate mapping, neighbor reads and the shared blend
// multiplier; holds the output register.
// ----------------------------------------------------------------------------
module bir_back import bir_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  geom_t           geom,
  input  wire logic       q_empty,
  input  cmd_t            q_head,
  output      logic       q_pop,
  output      logic       out_tvalid,
  input  wire logic       out_tready,
  output      logic [7:0] out_tdata,
  output      logic       out_tuser
);

  localparam int DEPTH  = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIVX = 3'd1;
  localparam logic [2:0] S_DIVY = 3'd2;
  localparam logic [2:0] S_ADDR = 3'd3;
  localparam logic [2:0] S_READ = 3'd4;
  localparam logic [2:0] S_MUL  = 3'd5;
  localparam logic [2:0] S_RES  = 3'd6;

  logic [2:0]  state_r, state_nxt;
  logic [2:0]  step_r;
  cmd_t        cmd_r;
  logic [31:0] px_r, py_r;
  logic [7:0]  xl_r, xh_r, yl_r, yh_r;
  logic [15:0] wx_r, wy_r;
  logic [7:0]  pix_r [4];
  logic [23:0] top_r, bot_r;
  logic [39:0] acc_r;
  logic [40:0] prod_r;
  logic [7:0]  res_pix_r;
  logic        res_err_r;
  logic        out_valid_r;
  logic [7:0]  out_pix_r;
  logic        out_err_r;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [7:0] row, input logic [7:0] col);
    addr_of = ADDR_W'(32'(row) * MAX_SRC_WIDTH + 32'(col));
  endfunction

  // ---------------- divider ----------------
  logic [7:0]       sw_m1, sh_m1;
  logic [8:0]       tw_m1, th_m1;
  logic             div_start, div_done;
  logic [DIV_W-1:0] div_num, div_q;
  logic [8:0]       div_den;
  logic [15:0]      span;

  assign sw_m1 = geom.sw - 8'd1;
  assign sh_m1 = geom.sh - 8'd1;
  assign tw_m1 = geom.tw - 9'd1;
  assign th_m1 = geom.th - 9'd1;

  assign q_pop     = (state_r == S_IDLE) && !q_empty;
  assign div_start = (q_pop && q_head.kind == KIND_COMP) || (state_r == S_DIVX && div_done);

  always_comb begin
    if (state_r == S_IDLE) begin
      span    = {8'd0, q_head.target_col} * {8'd0, sw_m1};
      div_den = tw_m1;
    end else begin
      span    = {8'd0, cmd_r.target_row} * {8'd0, sh_m1};
      div_den = th_m1;
    end
    div_num = {span, 16'd0};
  end

  bir_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_q)
  );

  // ---------------- neighbor indices ----------------
  logic [7:0] xl_c, yl_c;
  logic [8:0] xh_c, yh_c;

  always_comb begin
    xl_c = (px_r[31:16] > {8'd0, sw_m1}) ? sw_m1 : px_r[23:16];
    yl_c = (py_r[31:16] > {8'd0, sh_m1}) ? sh_m1 : py_r[23:16];
    xh_c = {1'b0, xl_c} + 9'd1;
    yh_c = {1'b0, yl_c} + 9'd1;
    if (xh_c > {1'b0, sw_m1}) xh_c = {1'b0, sw_m1};
    if (yh_c > {1'b0, sh_m1}) yh_c = {1'b0, sh_m1};
  end

  // ---------------- frame store ----------------
  logic [7:0]        mem [DEPTH];
  logic [7:0]        rd_data_r;
  logic [ADDR_W-1:0] mem_addr;
  logic              mem_we;

  assign mem_we = q_pop && q_head.kind == KIND_LOAD;

  always_comb begin
    if (state_r == S_IDLE) begin
      mem_addr = addr_of({1'b0, q_head.source_row}, {1'b0, q_head.source_col});
    end else begin
      unique case (step_r[1:0])
        2'd0:    mem_addr = addr_of(yl_r, xl_r);
        2'd1:    mem_addr = addr_of(yl_r, xh_r);
        2'd2:    mem_addr = addr_of(yh_r, xl_r);
        default: mem_addr = addr_of(yh_r, xh_r);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= q_head.pixel_value;
    rd_data_r <= mem[mem_addr];
  end

  // ---------------- shared multiplier ----------------
  logic [23:0] mul_a;
  logic [16:0] mul_b;
  logic [40:0] mul_p;
  logic [16:0] iwx, iwy;
  logic [40:0] sum;

  assign iwx   = 17'h10000 - {1'b0, wx_r};
  assign iwy   = 17'h10000 - {1'b0, wy_r};
  assign mul_p = mul_a * mul_b;
  assign sum   = {1'b0, acc_r} + prod_r;

  always_comb begin
    unique case (step_r)
      3'd0:    begin mul_a = {16'd0, pix_r[0]}; mul_b = iwx; end
      3'd1:    begin mul_a = {16'd0, pix_r[1]}; mul_b = {1'b0, wx_r}; end
      3'd2:    begin mul_a = {16'd0, pix_r[2]}; mul_b = iwx; end
      3'd3:    begin mul_a = {16'd0, pix_r[3]}; mul_b = {1'b0, wx_r}; end
      3'd4:    begin mul_a = top_r;            mul_b = iwy; end
      default: begin mul_a = bot_r;            mul_b = {1'b0, wy_r}; end
    endcase
  end

  // ---------------- sequencer ----------------
  logic out_free;
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (q_pop && q_head.kind == KIND_COMP)     state_nxt = S_DIVX;
        else if (q_pop && q_head.kind == KIND_ERR) state_nxt = S_RES;
      end
      S_DIVX: if (div_done) state_nxt = S_DIVY;
      S_DIVY: if (div_done) state_nxt = S_ADDR;
      S_ADDR: state_nxt = S_READ;
      S_READ: if (step_r == 3'd4) state_nxt = S_MUL;
      S_MUL:  if (step_r == 3'd6) state_nxt = S_RES;
      S_RES:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r != state_nxt) step_r <= '0;
      else if (state_r == S_READ || state_r == S_MUL) step_r <= step_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r     <= q_head;
      res_pix_r <= 8'd0;
      res_err_r <= (q_head.kind == KIND_ERR);
    end
    if (state_r == S_DIVX && div_done) px_r <= (tw_m1 == 9'd0) ? '0 : div_q;
    if (state_r == S_DIVY && div_done) py_r <= (th_m1 == 9'd0) ? '0 : div_q;
    if (state_r == S_ADDR) begin
      xl_r <= xl_c;
      yl_r <= yl_c;
      xh_r <= xh_c[7:0];
      yh_r <= yh_c[7:0];
      wx_r <= px_r[15:0];
      wy_r <= py_r[15:0];
    end
    if (state_r == S_READ && step_r != 3'd0) pix_r[step_r[1:0] - 2'd1] <= rd_data_r;
    if (state_r == S_MUL) begin
      prod_r <= mul_p;
      unique case (step_r)
        3'd1, 3'd3, 3'd5: acc_r <= prod_r[39:0];
        3'd2:             top_r <= sum[23:0];
        3'd4:             bot_r <= sum[23:0];
        3'd6:             res_pix_r <= sum[39:32];
        default:          ;
      endcase
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_RES && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_RES && out_free) begin
      out_pix_r <= res_pix_r;
      out_err_r <= res_err_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pix_r;
  assign out_tuser  = out_err_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> out_pix_r == 8'd0)
    else $error("error result carries a nonzero pixel");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIVX || state_r == S_DIVY))
    else $error("divider finished outside a divide state");

  a_neighbor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> ((xh_r == xl_r || xh_r == xl_r + 8'd1) && xh_r < geom.sw))
    else $error("column neighbors out of order");

  a_row_nb: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> ((yh_r == yl_r || yh_r == yl_r + 8'd1) && yh_r < geom.sh))
    else $error("row neighbors out of order");

endmodule
`default_nettype wire

@@ rtl/bilinear_image_resize.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bilinear_image_resize
// Bilinear resize of an 8-bit grayscale frame held in an on-chip store.
// ----------------------------------------------------------------------------
// Items enter a two-entry command queue at one per cycle while it has room.
// A load item writes the frame store as it leaves the queue. A compute
// item holds the back end while it leaves the queue, while two passes of
// the shared bit-serial divider (shifts and a handoff each) map the column
// and then the row to Q16 source positions, while the neighbor addresses
// are formed, during the four reads of the single-port store, while one
// shared multiplier forms the six weight products of the blend, and until
// it hands the result to the output register. An item whose coordinate
// lies outside the target size returns pixel 0 with the error flag. A
// result waits in the output register while the front keeps queueing
// items.
module bilinear_image_resize import bir_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [8:0]  cfg_data,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  // source_row[6:0], source_col[13:7], pixel_value[21:14],
  // target_row[29:22], target_col[37:30], zero pad [39:38]
  input  wire logic [39:0] in_tdata,
  // operation[0]
  input  wire logic        in_tuser,
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  // result_pixel[7:0]
  output      logic [7:0]  out_tdata,
  // coord_error[0]
  output      logic        out_tuser
);

  cmd_t  push_cmd, head;
  geom_t geom;
  logic  push, pop, full, empty;

  bir_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (full),
    .q_push    (push),
    .q_cmd     (push_cmd),
    .geom      (geom)
  );

  bir_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (full),
    .empty    (empty),
    .head     (head)
  );

  bir_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .geom       (geom),
    .q_empty    (empty),
    .q_head     (head),
    .q_pop      (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

@@ tb/sv/bilinear_image_resize_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_image_resize_test
// Self-checking bench for the bilinear resize block. Source pixels are
// loaded into a mirrored frame store and compute items are predicted from
// the mirror and the current geometry. Covers directed corner and edge cases,
// geometry extremes, random phases, a full drain and a stretch with no idling.
// ----------------------------------------------------------------------------
module bilinear_image_resize_test;
  import bir_pkg::*;

  localparam bit OP_LOAD    = 1'b0;
  localparam bit OP_COMPUTE = 1'b1;
  localparam int SRC_MAX    = 128;
  localparam int SETTLE     = 120;    // back-end latency margin, cycles
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    bit [7:0] pixel;
    bit       err;
  } pixel_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [8:0]  cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tuser;

  bilinear_image_resize uut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser
  );

  // mirrored state
  bit [7:0] pixel_mirror [SRC_MAX*SRC_MAX];
  bit       pixel_written [SRC_MAX*SRC_MAX];
  bit [7:0] reg_src_w = 8'd128, reg_src_h = 8'd128;
  bit [8:0] reg_dst_w = 9'd128, reg_dst_h = 9'd128;

  pixel_result_t pending_pixels[$];
  int  mismatches = 0;
  int  n_loads = 0, n_computes = 0, n_coord_errors = 0, n_geometries = 0;
  bit  in_idling = 1'b1, out_idling = 1'b1;
  int  out_stall = 0;
  int  quiet_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int eff_src(bit [7:0] v);
    return (v == 0) ? 1 : (v > SRC_MAX) ? SRC_MAX : int'(v);
  endfunction

  function automatic int eff_dst(bit [8:0] v);
    return (v > MAX_DST_WIDTH) ? MAX_DST_WIDTH : int'(v);
  endfunction

  function automatic bit [63:0] q16_position(int idx, int in_dim, int out_dim);
    if (out_dim <= 1) return 64'd0;
    return (64'(idx) * 64'(in_dim - 1) * 64'd65536) / 64'(out_dim - 1);
  endfunction

  // Resolve a target coordinate to its four store addresses and Q16 weights.
  function automatic void locate_neighbors(input bit [7:0] trow, input bit [7:0] tcol,
                                           output bit outside, output int adr[4],
                                           output bit [63:0] wx, output bit [63:0] wy);
    int sw, sh, xl, xh, yl, yh;
    bit [63:0] px, py;
    sw = eff_src(reg_src_w);
    sh = eff_src(reg_src_h);
    outside = (trow >= eff_dst(reg_dst_h)) || (tcol >= eff_dst(reg_dst_w));
    px = q16_position(tcol, sw, eff_dst(reg_dst_w));
    py = q16_position(trow, sh, eff_dst(reg_dst_h));
    xl = int'(px >> 16);
    yl = int'(py >> 16);
    wx = px & 64'hFFFF;
    wy = py & 64'hFFFF;
    if (xl > sw - 1) xl = sw - 1;
    if (yl > sh - 1) yl = sh - 1;
    // clamp the high neighbor at the last row and column
    xh = (xl + 1 > sw - 1) ? sw - 1 : xl + 1;
    yh = (yl + 1 > sh - 1) ? sh - 1 : yl + 1;
    adr[0] = yl * SRC_MAX + xl;
    adr[1] = yl * SRC_MAX + xh;
    adr[2] = yh * SRC_MAX + xl;
    adr[3] = yh * SRC_MAX + xh;
  endfunction

  function automatic pixel_result_t blend_pixel(bit [7:0] trow, bit [7:0] tcol);
    pixel_result_t r;
    bit outside;
    int adr[4];
    bit [63:0] wx, wy, total;
    locate_neighbors(trow, tcol, outside, adr, wx, wy);
    r.err = outside;
    r.pixel = 8'd0;
    if (!outside) begin
      total = 64'(pixel_mirror[adr[0]]) * (64'd65536 - wx) * (64'd65536 - wy)
            + 64'(pixel_mirror[adr[1]]) * wx * (64'd65536 - wy)
            + 64'(pixel_mirror[adr[2]]) * (64'd65536 - wx) * wy
            + 64'(pixel_mirror[adr[3]]) * wx * wy;
      r.pixel = total[39:32];
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int expd, int got);
    $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, expd, got);
    mismatches++;
  endtask

  // Send one item; returns at the edge where it is accepted.
  task automatic send_item(bit op, bit [6:0] srow, bit [6:0] scol, bit [7:0] pix,
                           bit [7:0] trow, bit [7:0] tcol);
    int gap;
    gap = (in_idling && $urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {2'b00, tcol, trow, pix, scol, srow};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (op == OP_LOAD) begin
      pixel_mirror[int'(srow) * SRC_MAX + scol] = pix;
      pixel_written[int'(srow) * SRC_MAX + scol] = 1'b1;
      n_loads++;
    end else begin
      pending_pixels.push_back(blend_pixel(trow, tcol));
      n_computes++;
    end
  endtask

  task automatic load_pixel(bit [6:0] row, bit [6:0] col, bit [7:0] pix);
    send_item(OP_LOAD, row, col, pix, 8'($urandom), 8'($urandom));
  endtask

  // Fill any unwritten neighbor first so no unwritten entry is ever read.
  task automatic request_pixel(bit [7:0] trow, bit [7:0] tcol);
    bit outside;
    int adr[4];
    bit [63:0] wx, wy;
    locate_neighbors(trow, tcol, outside, adr, wx, wy);
    if (!outside) begin
      foreach (adr[k]) begin
        if (!pixel_written[adr[k]])
          load_pixel(7'(adr[k] / SRC_MAX), 7'(adr[k] % SRC_MAX), 8'($urandom));
      end
    end
    send_item(OP_COMPUTE, 7'($urandom), 7'($urandom), 8'($urandom), trow, tcol);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_geometry(bit [7:0] sw, bit [7:0] sh, bit [8:0] tw, bit [8:0] th);
    drain_results();
    cfg_we <= 1'b1; cfg_index <= REG_SRC_W; cfg_data <= {1'b0, sw};
    @(posedge clk);
    cfg_index <= REG_SRC_H; cfg_data <= {1'b0, sh};
    @(posedge clk);
    cfg_index <= REG_DST_W; cfg_data <= tw;
    @(posedge clk);
    cfg_index <= REG_DST_H; cfg_data <= th;
    @(posedge clk);
    cfg_we <= 1'b0;
    reg_src_w = sw; reg_src_h = sh; reg_dst_w = tw; reg_dst_h = th;
    n_geometries++;
    @(posedge clk);
  endtask

  task automatic test_directed_corners();
    load_pixel(7'd0, 7'd0, 8'd255);
    load_pixel(7'd127, 7'd127, 8'd0);
    load_pixel(7'd0, 7'd127, 8'd0);
    load_pixel(7'd127, 7'd0, 8'd255);
    request_pixel(8'd0, 8'd0);
    request_pixel(8'd127, 8'd127);
    request_pixel(8'd64, 8'd33);
    request_pixel(8'd128, 8'd0);      // row outside target
    request_pixel(8'd0, 8'd255);      // column outside target
    request_pixel(8'd255, 8'd255);
  endtask

  task automatic test_geometry_extremes();
    set_geometry(8'd1, 8'd1, 9'd1, 9'd1);
    request_pixel(8'd0, 8'd0);
    request_pixel(8'd0, 8'd1);
    set_geometry(8'd0, 8'd200, 9'd300, 9'd256);   // sizes that clamp
    request_pixel(8'd255, 8'd255);
    request_pixel(8'd100, 8'd7);
    set_geometry(8'd255, 8'd2, 9'd0, 9'd511);     // zero width: all outside
    request_pixel(8'd0, 8'd0);
    set_geometry(8'd128, 8'd128, 9'd256, 9'd2);
    request_pixel(8'd1, 8'd255);
    request_pixel(8'd0, 8'd129);
  endtask

  function automatic bit [7:0] pick_src();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd128;
      3: return 8'($urandom_range(129, 255));
      default: return 8'($urandom_range(2, 16));
    endcase
  endfunction

  function automatic bit [8:0] pick_dst();
    case ($urandom_range(0, 9))
      0: return 9'd0;
      1: return 9'd1;
      2: return 9'd256;
      3: return 9'($urandom_range(257, 511));
      default: return 9'($urandom_range(2, 64));
    endcase
  endfunction

  task automatic random_items(int count);
    int tw, th;
    for (int i = 0; i < count; i++) begin
      tw = eff_dst(reg_dst_w);
      th = eff_dst(reg_dst_h);
      if ($urandom_range(0, 9) < 3)
        load_pixel(7'($urandom), 7'($urandom), 8'($urandom));
      else if ($urandom_range(0, 9) == 0 || tw == 0 || th == 0)
        request_pixel(8'($urandom), 8'($urandom));
      else
        request_pixel(8'($urandom_range(0, th - 1)), 8'($urandom_range(0, tw - 1)));
    end
  endtask

  task automatic test_random_geometries();
    for (int p = 0; p < 12; p++) begin
      set_geometry(pick_src(), pick_src(), pick_dst(), pick_dst());
      random_items(75);
    end
  endtask

  task automatic test_full_drain();
    set_geometry(8'd9, 8'd5, 9'd40, 9'd17);
    random_items(20);
    drain_results();   // sender holds until every result is back
    random_items(20);
  endtask

  task automatic test_no_idling();
    in_idling = 1'b0;
    out_idling = 1'b0;
    set_geometry(8'd16, 8'd12, 9'd64, 9'd48);
    random_items(150);
  endtask

  // Result side: random stall bursts.
  always @(posedge clk) begin
    if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_tready <= 1'b0;
    end else if (out_idling && $urandom_range(0, 5) == 0) begin
      out_stall <= $urandom_range(0, 16);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    pixel_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected result pixel", -1, out_tdata);
      end else begin
        want = pending_pixels.pop_front();
        if (out_tdata !== want.pixel) report_mismatch("result_pixel", want.pixel, out_tdata);
        if (out_tuser !== want.err) report_mismatch("coord_error", want.err, out_tuser);
        if (want.err) n_coord_errors++;
      end
    end
  end

  // Watchdog: cycles with no handshake on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_corners();
    test_geometry_extremes();
    test_random_geometries();
    test_full_drain();
    test_no_idling();
    drain_results();
    $display("covered %0d loads, %0d computes (%0d outside target) over %0d geometries",
             n_loads, n_computes, n_coord_errors, n_geometries);
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/bir_pkg.sv
rtl/bir_front.sv
rtl/bir_queue.sv
rtl/bir_div.sv
rtl/bir_back.sv
rtl/bilinear_image_resize.sv
tb/sv/bilinear_image_resize_test.sv
